// ===== sv/qmae_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qmae_pkg
// Shared types, codes and probability tables of the QM binary arithmetic
// encoder.
// ----------------------------------------------------------------------------
package qmae_pkg;

    localparam int CONTEXTS_DEF = 4096;
    localparam int CTX_IN_W     = 12;
    localparam int CTX_W        = 16;
    localparam int NSTATES      = 113;
    localparam int Q_DEPTH      = 2;

    localparam logic [1:0] OP_CTX     = 2'd0;
    localparam logic [1:0] OP_DIRECT  = 2'd1;
    localparam logic [1:0] OP_FLUSH   = 2'd2;
    localparam logic [1:0] OP_RESTART = 2'd3;

    localparam logic [1:0] KIND_BYTE     = 2'd0;
    localparam logic [1:0] KIND_ZERO_RUN = 2'd1;
    localparam logic [1:0] KIND_PAIR_RUN = 2'd2;

    localparam logic [16:0] A_INIT    = 17'h10000;
    localparam logic [16:0] A_HALF    = 17'h08000;
    localparam logic [3:0]  CT_INIT   = 4'd11;
    localparam logic [3:0]  CT_BYTE   = 4'd8;
    localparam logic [27:0] C_LOW_MSK = 28'h007ffff;

    typedef struct packed {
        logic [1:0]       op;
        logic             sym;
        logic [CTX_W-1:0] ctx;
        logic [14:0]      prob;
        logic             mps;
    } qmae_entry_t;

    typedef enum logic [0:0] {
        FR_IDLE,
        FR_MOD
    } qmae_front_state_t;

    typedef enum logic [3:0] {
        CS_CLEAR,
        CS_IDLE,
        CS_READ,
        CS_CODE,
        CS_RENORM,
        CS_BO_A,
        CS_BO_B,
        CS_BO_C,
        CS_FL0,
        CS_FL1,
        CS_FL2,
        CS_FL3,
        CS_FL4,
        CS_FL5,
        CS_FIN
    } qmae_core_state_t;

    localparam logic [14:0] QE_TAB [NSTATES] = '{
        15'h5a1d, 15'h2586, 15'h1114, 15'h080b, 15'h03d8, 15'h01da, 15'h00e5, 15'h006f,
        15'h0036, 15'h001a, 15'h000d, 15'h0006, 15'h0003, 15'h0001, 15'h5a7f, 15'h3f25,
        15'h2cf2, 15'h207c, 15'h17b9, 15'h1182, 15'h0cef, 15'h09a1, 15'h072f, 15'h055c,
        15'h0406, 15'h0303, 15'h0240, 15'h01b1, 15'h0144, 15'h00f5, 15'h00b7, 15'h008a,
        15'h0068, 15'h004e, 15'h003b, 15'h002c, 15'h5ae1, 15'h484c, 15'h3a0d, 15'h2ef1,
        15'h261f, 15'h1f33, 15'h19a8, 15'h1518, 15'h1177, 15'h0e74, 15'h0bfb, 15'h09f8,
        15'h0861, 15'h0706, 15'h05cd, 15'h04de, 15'h040f, 15'h0363, 15'h02d4, 15'h025c,
        15'h01f8, 15'h01a4, 15'h0160, 15'h0125, 15'h00f6, 15'h00cb, 15'h00ab, 15'h008f,
        15'h5b12, 15'h4d04, 15'h412c, 15'h37d8, 15'h2fe8, 15'h293c, 15'h2379, 15'h1edf,
        15'h1aa9, 15'h174e, 15'h1424, 15'h119c, 15'h0f6b, 15'h0d51, 15'h0bb6, 15'h0a40,
        15'h5832, 15'h4d1c, 15'h438e, 15'h3bdd, 15'h34ee, 15'h2eae, 15'h299a, 15'h2516,
        15'h5570, 15'h4ca9, 15'h44d9, 15'h3e22, 15'h3824, 15'h32b4, 15'h2e17, 15'h56a8,
        15'h4f46, 15'h47e5, 15'h41cf, 15'h3c3d, 15'h375e, 15'h5231, 15'h4c0f, 15'h4639,
        15'h415e, 15'h5627, 15'h50e7, 15'h4b85, 15'h5597, 15'h504f, 15'h5a10, 15'h5522,
        15'h59eb
    };

    localparam logic [6:0] NLPS_TAB [NSTATES] = '{
        7'd1,   7'd14,  7'd16,  7'd18,  7'd20,  7'd23,  7'd25,  7'd28,  7'd30,  7'd33,
        7'd35,  7'd9,   7'd10,  7'd12,  7'd15,  7'd36,  7'd38,  7'd39,  7'd40,  7'd42,
        7'd43,  7'd45,  7'd46,  7'd48,  7'd49,  7'd51,  7'd52,  7'd54,  7'd56,  7'd57,
        7'd59,  7'd60,  7'd62,  7'd63,  7'd32,  7'd33,  7'd37,  7'd64,  7'd65,  7'd67,
        7'd68,  7'd69,  7'd70,  7'd72,  7'd73,  7'd74,  7'd75,  7'd77,  7'd78,  7'd79,
        7'd48,  7'd50,  7'd50,  7'd51,  7'd52,  7'd53,  7'd54,  7'd55,  7'd56,  7'd57,
        7'd58,  7'd59,  7'd61,  7'd61,  7'd65,  7'd80,  7'd81,  7'd82,  7'd83,  7'd84,
        7'd86,  7'd87,  7'd87,  7'd72,  7'd72,  7'd74,  7'd74,  7'd75,  7'd77,  7'd77,
        7'd80,  7'd88,  7'd89,  7'd90,  7'd91,  7'd92,  7'd93,  7'd86,  7'd88,  7'd95,
        7'd96,  7'd97,  7'd99,  7'd99,  7'd93,  7'd95,  7'd101, 7'd102, 7'd103, 7'd104,
        7'd99,  7'd105, 7'd106, 7'd107, 7'd103, 7'd105, 7'd108, 7'd109, 7'd110, 7'd111,
        7'd110, 7'd112, 7'd112
    };

    localparam logic [6:0] NMPS_TAB [NSTATES] = '{
        7'd1,   7'd2,   7'd3,   7'd4,   7'd5,   7'd6,   7'd7,   7'd8,   7'd9,   7'd10,
        7'd11,  7'd12,  7'd13,  7'd13,  7'd15,  7'd16,  7'd17,  7'd18,  7'd19,  7'd20,
        7'd21,  7'd22,  7'd23,  7'd24,  7'd25,  7'd26,  7'd27,  7'd28,  7'd29,  7'd30,
        7'd31,  7'd32,  7'd33,  7'd34,  7'd35,  7'd9,   7'd37,  7'd38,  7'd39,  7'd40,
        7'd41,  7'd42,  7'd43,  7'd44,  7'd45,  7'd46,  7'd47,  7'd48,  7'd49,  7'd50,
        7'd51,  7'd52,  7'd53,  7'd54,  7'd55,  7'd56,  7'd57,  7'd58,  7'd59,  7'd60,
        7'd61,  7'd62,  7'd63,  7'd32,  7'd65,  7'd66,  7'd67,  7'd68,  7'd69,  7'd70,
        7'd71,  7'd72,  7'd73,  7'd74,  7'd75,  7'd76,  7'd77,  7'd78,  7'd79,  7'd48,
        7'd81,  7'd82,  7'd83,  7'd84,  7'd85,  7'd86,  7'd87,  7'd71,  7'd89,  7'd90,
        7'd91,  7'd92,  7'd93,  7'd94,  7'd86,  7'd96,  7'd97,  7'd98,  7'd99,  7'd100,
        7'd93,  7'd102, 7'd103, 7'd104, 7'd99,  7'd106, 7'd107, 7'd103, 7'd109, 7'd107,
        7'd111, 7'd109, 7'd111
    };

    localparam logic SWITCH_TAB [NSTATES] = '{
        1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
        1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
        1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
        1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0,
        1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
        1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
        1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
        1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
        1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0,
        1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0,
        1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0,
        1'b1, 1'b0, 1'b1
    };

endpackage
`default_nettype wire

// ===== sv/qmae_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qmae_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module qmae_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule
`default_nettype wire

// ===== sv/qmae_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qmae_queue
// Short FIFO of classified commands between the front end and the coder.
// ----------------------------------------------------------------------------
module qmae_queue
    import qmae_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        push,
    input  wire qmae_entry_t push_entry,
    output logic             full,
    input  wire logic        pop,
    output logic             valid,
    output qmae_entry_t      head
);

    localparam int PW = $clog2(Q_DEPTH);
    localparam int CW = $clog2(Q_DEPTH + 1);

    qmae_entry_t     slot_reg [Q_DEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg, count_next;
    logic            do_push, do_pop;

    assign full    = (count_reg == CW'(Q_DEPTH));
    assign valid   = (count_reg != '0);
    assign head    = slot_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PW'(Q_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PW'(Q_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule
`default_nettype wire

// ===== sv/qmae_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qmae_front
// Input front end: takes commands, reduces the context index to the
// context store's range and queues the command for the coder.
// ----------------------------------------------------------------------------
module qmae_front
    import qmae_pkg::*;
#(
    parameter int CONTEXTS = CONTEXTS_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire qmae_entry_t in_entry,
    input  wire logic        clear_busy,
    output logic             push,
    output qmae_entry_t      push_entry,
    input  wire logic        q_full
);

    localparam int AW = $clog2(CONTEXTS);
    // Only a non power of two smaller than the index range needs a true remainder.
    localparam bit MOD_NEEDED = (CONTEXTS < (1 << CTX_IN_W)) &&
                                ((CONTEXTS & (CONTEXTS - 1)) != 0);
    localparam int SH    = CTX_IN_W + AW;
    localparam int MUL_W = CTX_IN_W + 2;
    // reciprocal rounded up gives the exact quotient for every index
    localparam logic [MUL_W-1:0] RECIP =
        MUL_W'(((longint'(1) << SH) + longint'(CONTEXTS) - 1) / longint'(CONTEXTS));
    localparam logic [CTX_IN_W-1:0] CTX_N = CTX_IN_W'(CONTEXTS);

    qmae_front_state_t          state_reg, state_next;
    qmae_entry_t                entry_reg, entry_next;
    logic [CTX_IN_W-1:0]        sh_reg, sh_next;
    logic [CTX_IN_W-1:0]        quo_reg, quo_next;
    logic [AW-1:0]              rem_reg, rem_next;
    logic [1:0]                 cnt_reg, cnt_next;
    logic [MUL_W+CTX_IN_W-1:0]  prod;
    logic [CTX_IN_W-1:0]        diff;
    logic                       accept, mod_done;
    logic [AW-1:0]              direct_addr;
    qmae_entry_t                direct_entry;

    assign direct_addr = AW'(in_entry.ctx[CTX_IN_W-1:0]);
    assign accept      = in_valid && in_ready;
    assign mod_done    = (cnt_reg == 2'd2);
    assign prod        = {{MUL_W{1'b0}}, sh_reg} * {{CTX_IN_W{1'b0}}, RECIP};
    assign diff        = sh_reg - quo_reg * CTX_N;

    always_comb begin
        direct_entry     = in_entry;
        direct_entry.ctx = CTX_W'(direct_addr);
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            FR_IDLE: begin
                if (accept && MOD_NEEDED && in_entry.op == OP_CTX) begin
                    state_next = FR_MOD;
                end
            end
            FR_MOD: begin
                if (mod_done && !q_full) begin
                    state_next = FR_IDLE;
                end
            end
            default: state_next = FR_IDLE;
        endcase
    end

    always_comb begin
        in_ready   = 1'b0;
        push       = 1'b0;
        push_entry = direct_entry;
        entry_next = entry_reg;
        sh_next    = sh_reg;
        quo_next   = quo_reg;
        rem_next   = rem_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            FR_IDLE: begin
                in_ready = !q_full && !clear_busy;
                if (accept) begin
                    if (MOD_NEEDED && in_entry.op == OP_CTX) begin
                        entry_next = in_entry;
                        sh_next    = in_entry.ctx[CTX_IN_W-1:0];
                        rem_next   = '0;
                        cnt_next   = '0;
                    end else begin
                        push = 1'b1;
                    end
                end
            end
            FR_MOD: begin
                if (cnt_reg == 2'd0) begin
                    // quotient by reciprocal multiply, remainder in the next cycle
                    quo_next = CTX_IN_W'(prod >> SH);
                    cnt_next = 2'd1;
                end else if (cnt_reg == 2'd1) begin
                    rem_next = AW'(diff);
                    cnt_next = 2'd2;
                end else begin
                    push           = !q_full;
                    push_entry     = entry_reg;
                    push_entry.ctx = CTX_W'(rem_reg);
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= FR_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
        sh_reg    <= sh_next;
        quo_reg   <= quo_next;
        rem_reg   <= rem_next;
    end

endmodule
`default_nettype wire

// ===== sv/qmae_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qmae_core
// Coding back end: context lookup and update, interval arithmetic, shift
// by shift renormalization, byte output with carry and 0xff stacking,
// flush, and the registered result port.
// ----------------------------------------------------------------------------
module qmae_core
    import qmae_pkg::*;
#(
    parameter int CONTEXTS = CONTEXTS_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        q_valid,
    input  wire qmae_entry_t q_head,
    output logic             q_pop,
    output logic             clear_busy,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [1:0]       out_kind,
    output logic [7:0]       out_byte,
    output logic [31:0]      out_run,
    output logic             out_last
);

    localparam int AW = $clog2(CONTEXTS);

    qmae_core_state_t state_reg, state_next;
    qmae_core_state_t ret_reg, ret_next;
    qmae_entry_t      cur_reg, cur_next;
    logic [16:0]      a_reg, a_next;
    logic [27:0]      c_reg, c_next;
    logic [3:0]       ct_reg, ct_next;
    logic [7:0]       pend_reg, pend_next;
    logic [31:0]      stack_reg, stack_next;
    logic             first_reg, first_next;
    logic [6:0]       st_reg, st_next;
    logic             mps_reg, mps_next;
    logic [14:0]      qe_reg, qe_next;
    logic [28:0]      fl_reg, fl_next;
    logic [AW-1:0]    clr_reg, clr_next;

    logic             hold_valid_reg, hold_valid_next;
    logic [1:0]       hold_kind_reg;
    logic [7:0]       hold_byte_reg;
    logic [31:0]      hold_run_reg;
    logic             m_valid_reg, m_valid_next;
    logic [1:0]       m_kind_reg;
    logic [7:0]       m_byte_reg;
    logic [31:0]      m_run_reg;
    logic             m_last_reg;

    logic             emit_req;
    logic [1:0]       emit_kind;
    logic [7:0]       emit_byte;
    logic [31:0]      emit_run;
    logic             out_free, can_emit, stall, advance, load_mid, load_fin;

    logic             ram_we;
    logic [AW-1:0]    ram_wa;
    logic [7:0]       ram_wd;
    logic [7:0]       ram_rd;

    logic [16:0]      a_sub;
    logic             is_mps, code_renorm;
    logic [8:0]       bt;
    logic [3:0]       ct_dec;
    logic [7:0]       pend_inc;
    logic [6:0]       rd_st;
    logic [28:0]      fl_sum, fl_mask;
    logic [43:0]      fl_shift;

    qmae_ram #(
        .WIDTH (8),
        .DEPTH (CONTEXTS)
    ) u_ctx_ram (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_wa),
        .wr_data (ram_wd),
        .rd_addr (q_head.ctx[AW-1:0]),
        .rd_data (ram_rd)
    );

    assign a_sub       = a_reg - 17'(qe_reg);
    assign is_mps      = (cur_reg.sym == mps_reg);
    assign code_renorm = !is_mps || (a_sub < A_HALF);
    assign bt          = c_reg[27:19];
    assign ct_dec      = ct_reg - 4'd1;
    assign pend_inc    = pend_reg + 8'd1;
    assign rd_st       = (ram_rd[6:0] < 7'(NSTATES)) ? ram_rd[6:0] : 7'd0;
    assign fl_sum      = 29'(c_reg) + 29'(a_reg) - 29'd1;
    assign fl_mask     = {fl_sum[28:16], 16'h0000};
    assign fl_shift    = {15'b0, fl_reg} << ct_reg;
    assign clear_busy  = (state_reg == CS_CLEAR);

    assign out_free = !m_valid_reg || out_ready;
    assign can_emit = !hold_valid_reg || out_free;
    assign stall    = (emit_req && !can_emit) ||
                      (state_reg == CS_FIN && hold_valid_reg && !out_free);
    assign advance  = !stall;
    assign load_mid = advance && emit_req && hold_valid_reg;
    assign load_fin = (state_reg == CS_FIN) && hold_valid_reg && out_free;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            CS_CLEAR:  if (clr_reg == AW'(CONTEXTS - 1)) state_next = CS_IDLE;
            CS_IDLE: begin
                if (q_valid) begin
                    unique case (q_head.op)
                        OP_CTX:    state_next = CS_READ;
                        OP_DIRECT: state_next = CS_CODE;
                        OP_FLUSH:  state_next = CS_FL0;
                        OP_RESTART: state_next = CS_FIN;
                        default:   state_next = CS_FIN;
                    endcase
                end
            end
            CS_READ:   state_next = CS_CODE;
            CS_CODE:   state_next = code_renorm ? CS_RENORM : CS_FIN;
            CS_RENORM: begin
                if (a_reg < A_HALF) begin
                    state_next = (ct_dec == 4'd0) ? CS_BO_A : CS_RENORM;
                end else begin
                    state_next = CS_FIN;
                end
            end
            CS_BO_A:   state_next = (bt == 9'h0ff) ? ret_reg : CS_BO_B;
            CS_BO_B:   state_next = CS_BO_C;
            CS_BO_C:   state_next = ret_reg;
            CS_FL0:    state_next = CS_FL1;
            CS_FL1:    state_next = CS_BO_A;
            CS_FL2:    state_next = CS_BO_A;
            CS_FL3:    state_next = CS_FL4;
            CS_FL4:    state_next = CS_FL5;
            CS_FL5:    state_next = CS_FIN;
            CS_FIN:    state_next = CS_IDLE;
            default:   state_next = CS_IDLE;
        endcase
        if (stall) begin
            state_next = state_reg;
        end
    end

    // datapath and result requests
    always_comb begin
        ret_next   = ret_reg;
        cur_next   = cur_reg;
        a_next     = a_reg;
        c_next     = c_reg;
        ct_next    = ct_reg;
        pend_next  = pend_reg;
        stack_next = stack_reg;
        first_next = first_reg;
        st_next    = st_reg;
        mps_next   = mps_reg;
        qe_next    = qe_reg;
        fl_next    = fl_reg;
        clr_next   = clr_reg;
        emit_req   = 1'b0;
        emit_kind  = KIND_BYTE;
        emit_byte  = 8'h00;
        emit_run   = 32'h0;
        ram_we     = 1'b0;
        ram_wa     = cur_reg.ctx[AW-1:0];
        ram_wd     = 8'h00;
        q_pop      = 1'b0;
        unique case (state_reg)
            CS_CLEAR: begin
                ram_we   = 1'b1;
                ram_wa   = clr_reg;
                clr_next = clr_reg + 1'b1;
            end
            CS_IDLE: begin
                if (q_valid) begin
                    q_pop    = 1'b1;
                    cur_next = q_head;
                    if (q_head.op == OP_DIRECT) begin
                        st_next  = 7'd0;
                        mps_next = q_head.mps;
                        qe_next  = (q_head.prob == 15'd0) ? 15'd1 : q_head.prob;
                    end else if (q_head.op == OP_RESTART) begin
                        a_next     = A_INIT;
                        c_next     = '0;
                        ct_next    = CT_INIT;
                        pend_next  = '0;
                        stack_next = '0;
                        first_next = 1'b0;
                    end
                end
            end
            CS_READ: begin
                st_next  = rd_st;
                mps_next = ram_rd[7];
                qe_next  = QE_TAB[rd_st];
            end
            CS_CODE: begin
                a_next = a_sub;
                if (is_mps) begin
                    if (a_sub < A_HALF) begin
                        if (a_sub < 17'(qe_reg)) begin
                            c_next = c_reg + 28'(a_sub);
                            a_next = 17'(qe_reg);
                        end
                        st_next = NMPS_TAB[st_reg];
                    end
                end else begin
                    if (a_sub >= 17'(qe_reg)) begin
                        c_next = c_reg + 28'(a_sub);
                        a_next = 17'(qe_reg);
                    end
                    if (SWITCH_TAB[st_reg]) begin
                        mps_next = !mps_reg;
                    end
                    st_next = NLPS_TAB[st_reg];
                end
                ram_we = (cur_reg.op == OP_CTX);
                ram_wd = {mps_next, st_next};
            end
            CS_RENORM: begin
                if (a_reg < A_HALF) begin
                    a_next  = {a_reg[15:0], 1'b0};
                    c_next  = {c_reg[26:0], 1'b0};
                    ct_next = ct_dec;
                    if (ct_dec == 4'd0) begin
                        ct_next  = CT_BYTE;
                        ret_next = CS_RENORM;
                    end
                end
            end
            CS_BO_A: begin
                if (bt == 9'h0ff) begin
                    stack_next = stack_reg + 32'd1;
                    c_next     = c_reg & C_LOW_MSK;
                end else if (bt[8]) begin
                    // carry into the pending byte; a carry into 0xff emits it first
                    pend_next = pend_inc;
                    if (pend_inc == 8'hff) begin
                        pend_next = 8'h00;
                        if (first_reg) begin
                            emit_req  = 1'b1;
                            emit_byte = 8'hff;
                        end else begin
                            first_next = 1'b1;
                        end
                    end
                end
            end
            CS_BO_B, CS_FL3: begin
                if (first_reg) begin
                    emit_req  = 1'b1;
                    emit_byte = pend_reg;
                end else begin
                    first_next = 1'b1;
                end
            end
            CS_BO_C: begin
                if (stack_reg != 32'd0) begin
                    emit_req  = 1'b1;
                    emit_kind = bt[8] ? KIND_ZERO_RUN : KIND_PAIR_RUN;
                    emit_run  = stack_reg;
                end
                stack_next = '0;
                pend_next  = bt[7:0];
                c_next     = c_reg & C_LOW_MSK;
            end
            CS_FL0: begin
                fl_next = (fl_mask < 29'(c_reg)) ? fl_mask + 29'h8000 : fl_mask;
            end
            CS_FL1: begin
                c_next   = fl_shift[27:0];
                ret_next = CS_FL2;
            end
            CS_FL2: begin
                c_next   = {c_reg[19:0], 8'h00};
                ret_next = CS_FL3;
            end
            CS_FL4, CS_FL5: begin
                if (first_reg) begin
                    emit_req  = 1'b1;
                    emit_byte = 8'hff;
                end else begin
                    first_next = 1'b1;
                end
            end
            CS_FIN: ;
            default: ;
        endcase
    end

    // result hold stage and output register
    always_comb begin
        hold_valid_next = hold_valid_reg;
        if (advance && emit_req) begin
            hold_valid_next = 1'b1;
        end else if (load_fin) begin
            hold_valid_next = 1'b0;
        end
        m_valid_next = (load_mid || load_fin) ? 1'b1 : (m_valid_reg && !out_ready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= CS_CLEAR;
            ret_reg        <= CS_FIN;
            clr_reg        <= '0;
            a_reg          <= A_INIT;
            c_reg          <= '0;
            ct_reg         <= CT_INIT;
            pend_reg       <= '0;
            stack_reg      <= '0;
            first_reg      <= 1'b0;
            hold_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            hold_valid_reg <= hold_valid_next;
            m_valid_reg    <= m_valid_next;
            if (advance) begin
                ret_reg   <= ret_next;
                clr_reg   <= clr_next;
                a_reg     <= a_next;
                c_reg     <= c_next;
                ct_reg    <= ct_next;
                pend_reg  <= pend_next;
                stack_reg <= stack_next;
                first_reg <= first_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            cur_reg <= cur_next;
            st_reg  <= st_next;
            mps_reg <= mps_next;
            qe_reg  <= qe_next;
            fl_reg  <= fl_next;
        end
        if (advance && emit_req) begin
            hold_kind_reg <= emit_kind;
            hold_byte_reg <= emit_byte;
            hold_run_reg  <= emit_run;
        end
        if (load_mid || load_fin) begin
            m_kind_reg <= hold_kind_reg;
            m_byte_reg <= hold_byte_reg;
            m_run_reg  <= hold_run_reg;
            m_last_reg <= load_fin;
        end
    end

    assign out_valid = m_valid_reg;
    assign out_kind  = m_kind_reg;
    assign out_byte  = m_byte_reg;
    assign out_run   = m_run_reg;
    assign out_last  = m_last_reg;

endmodule
`default_nettype wire

// ===== sv/qm_binary_arith_encoder.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qm_binary_arith_encoder
// QM-coder adaptive binary arithmetic encoder with a per-context
// probability state store.
// ----------------------------------------------------------------------------
// Commands enter on the s_ stream (s_tuser = opcode) and coded output leaves
// on the m_ stream: single bytes, runs of 0x00 bytes and runs of 0xff,0x00
// pairs, with m_tlast on the final result of each command.
// A front end classifies commands and queues up to two of them; the coder
// works on one command at a time and takes the next from the queue when idle.
// Context coding reads the context store before coding, direct coding skips
// the read; renormalization shifts one bit per step, and each output byte goes
// through the byte-output states (only the first when a 0xff byte is stacked).
// A restart goes straight to the final state and a flush runs its own states.
// Results do not slow the coder while the receiver keeps up; the last result
// of a command enters the output register in the command's final state. With
// CONTEXTS not a power of two and below 4096, a context command first has its
// index reduced in the front end. After reset the context store is cleared one
// entry per cycle (CONTEXTS entries, 4096 by default); s_tready is low until done.
// When the receiver holds m_tready low, one result waits in the output
// register and one more in a hold stage; the coder then stops until space
// frees up, and input is taken as long as the queue has room.
// ----------------------------------------------------------------------------
module qm_binary_arith_encoder
    import qmae_pkg::*;
#(
    parameter int CONTEXTS = CONTEXTS_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,  // symbol, context_index[12:1], probability[27:13],
                                       // given_mps[28], zero fill
    input  wire logic [1:0]  s_tuser,  // opcode
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata,  // byte_value[7:0], run_count[39:8]
    output logic [1:0]       m_tuser,  // item_kind
    output logic             m_tlast
);

    qmae_entry_t in_entry, push_entry, q_head;
    logic        push, q_full, q_valid, q_pop, clear_busy;
    logic [1:0]  out_kind;
    logic [7:0]  out_byte;
    logic [31:0] out_run;

    always_comb begin
        in_entry.op   = s_tuser;
        in_entry.sym  = s_tdata[0];
        in_entry.ctx  = CTX_W'(s_tdata[12:1]);
        in_entry.prob = s_tdata[27:13];
        in_entry.mps  = s_tdata[28];
    end

    qmae_front #(
        .CONTEXTS (CONTEXTS)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_entry   (in_entry),
        .clear_busy (clear_busy),
        .push       (push),
        .push_entry (push_entry),
        .q_full     (q_full)
    );

    qmae_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .full       (q_full),
        .pop        (q_pop),
        .valid      (q_valid),
        .head       (q_head)
    );

    qmae_core #(
        .CONTEXTS (CONTEXTS)
    ) u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .q_valid    (q_valid),
        .q_head     (q_head),
        .q_pop      (q_pop),
        .clear_busy (clear_busy),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_kind   (out_kind),
        .out_byte   (out_byte),
        .out_run    (out_run),
        .out_last   (m_tlast)
    );

    assign m_tdata = {out_run, out_byte};
    assign m_tuser = out_kind;

endmodule
`default_nettype wire

// ===== sv/qmae_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qmae_checker
// Port-level checks on the encoder's result stream.
// ----------------------------------------------------------------------------
module qmae_checker
    import qmae_pkg::*;
(
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [39:0] m_tdata,
    input wire logic [1:0]  m_tuser,
    input wire logic        m_tlast
);

    // hold a stalled result
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) &&
                                  $stable(m_tuser) && $stable(m_tlast))
        else $error("stalled result changed");

    assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tuser == KIND_BYTE || m_tuser == KIND_ZERO_RUN ||
                     m_tuser == KIND_PAIR_RUN)
        else $error("bad item kind");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == KIND_BYTE |-> m_tdata[39:8] == 32'h0)
        else $error("byte item with a run count");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != KIND_BYTE |-> m_tdata[39:8] != 32'h0 &&
                                             m_tdata[7:0] == 8'h00)
        else $error("empty run or run with a byte value");

endmodule

bind qm_binary_arith_encoder qmae_checker u_qmae_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
`default_nettype wire

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stream-level test of the QM binary arithmetic encoder: commands are driven
// with random gaps, a local QM-coder model predicts every coded result, and a
// checker compares each result transfer against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;
    import qmae_pkg::*;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  byte_val;
        logic [31:0] run;
        logic        lst;
    } coded_item_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;

    qm_binary_arith_encoder i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .m_tlast (m_tlast)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    // encoder model state
    logic [6:0]  ctx_st [CONTEXTS_DEF];
    logic        ctx_mps [CONTEXTS_DEF];
    logic [31:0] enc_a, enc_c, enc_ct, enc_buf, enc_sc;
    logic        enc_started;

    coded_item_t coded_q[$];
    coded_item_t cmd_out[$];
    int          n_errors = 0;
    bit          rx_hold = 1'b0;

    task automatic emit_coded(input logic [1:0] kind, input logic [7:0] b,
                              input logic [31:0] run);
        coded_item_t it;
        it.kind = kind;
        it.byte_val = b;
        it.run = run;
        it.lst = 1'b0;
        cmd_out.push_back(it);
    endtask

    task automatic put_coded_byte(input logic [7:0] b);
        if (!enc_started) begin
            enc_started = 1'b1;
        end else begin
            emit_coded(KIND_BYTE, b, 32'd0);
        end
    endtask

    task automatic put_coded_run(input logic [1:0] kind, input logic [31:0] n);
        if (n != 0) begin
            emit_coded(kind, 8'd0, n);
        end
    endtask

    task automatic shift_out_byte();
        logic [31:0] t;
        t = enc_c >> 19;
        if (t > 32'hff) begin
            enc_buf = (enc_buf + 1) & 32'hff;
            if (enc_buf == 32'hff) begin
                put_coded_byte(8'hff);
                enc_buf = 0;
            end
            put_coded_byte(enc_buf[7:0]);
            put_coded_run(KIND_ZERO_RUN, enc_sc);
            enc_sc = 0;
            enc_buf = t & 32'hff;
        end else if (t == 32'hff) begin
            enc_sc = enc_sc + 1;
        end else begin
            put_coded_byte(enc_buf[7:0]);
            put_coded_run(KIND_PAIR_RUN, enc_sc);
            enc_sc = 0;
            enc_buf = t;
        end
        enc_c = enc_c & 32'h7ffff;
    endtask

    task automatic renormalize();
        while (enc_a < 32'h8000) begin
            enc_a = enc_a << 1;
            enc_c = (enc_c << 1) & 32'h0fffffff;
            enc_ct = (enc_ct - 1) & 32'hf;
            if (enc_ct == 0) begin
                shift_out_byte();
                enc_ct = 8;
            end
        end
    endtask

    task automatic code_one_bit(input logic sym, input logic mps, input logic [31:0] qe,
                                input logic [6:0] st, output logic [6:0] nst,
                                output logic nmps);
        nst = st;
        nmps = mps;
        enc_a = enc_a - qe;
        if (sym == mps) begin
            if (enc_a < 32'h8000) begin
                if (enc_a < qe) begin
                    enc_c = (enc_c + enc_a) & 32'h0fffffff;
                    enc_a = qe;
                end
                nst = NMPS_TAB[st];
                renormalize();
            end
        end else begin
            if (enc_a >= qe) begin
                enc_c = (enc_c + enc_a) & 32'h0fffffff;
                enc_a = qe;
            end
            if (SWITCH_TAB[st]) nmps = ~mps;
            nst = NLPS_TAB[st];
            renormalize();
        end
    endtask

    task automatic restart_coder();
        enc_a = 32'h10000;
        enc_c = 0;
        enc_ct = 11;
        enc_buf = 0;
        enc_sc = 0;
        enc_started = 1'b0;
    endtask

    task automatic flush_coder();
        logic [31:0] t;
        t = (enc_c + enc_a - 1) & 32'hffff0000;
        if (t < enc_c) t = t + 32'h8000;
        enc_c = (t << enc_ct[3:0]) & 32'h0fffffff;
        shift_out_byte();
        enc_c = (enc_c << 8) & 32'h0fffffff;
        shift_out_byte();
        put_coded_byte(enc_buf[7:0]);
        put_coded_byte(8'hff);
        put_coded_byte(8'hff);
    endtask

    // predict results of one command and queue them
    task automatic predict_command(input logic [1:0] op, input logic sym,
                                   input logic [11:0] ctx, input logic [14:0] prob,
                                   input logic gmps);
        logic [6:0]  st, nst;
        logic        nm;
        logic [31:0] qe;
        cmd_out.delete();
        case (op)
            OP_CTX: begin
                st = ctx_st[ctx];
                if (st >= NSTATES) st = 0;
                code_one_bit(sym, ctx_mps[ctx], {17'd0, QE_TAB[st]}, st, nst, nm);
                ctx_st[ctx] = nst;
                ctx_mps[ctx] = nm;
            end
            OP_DIRECT: begin
                qe = (prob == 0) ? 32'd1 : {17'd0, prob};
                code_one_bit(sym, gmps, qe, 7'd0, nst, nm);
            end
            OP_FLUSH: flush_coder();
            default: restart_coder();
        endcase
        if (cmd_out.size() > 0) cmd_out[cmd_out.size()-1].lst = 1'b1;
        foreach (cmd_out[i]) coded_q.push_back(cmd_out[i]);
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // valid stays high after the transfer; the next call drops it or reloads it
    task automatic send_command(input logic [1:0] op, input logic sym,
                                input logic [11:0] ctx, input logic [14:0] prob,
                                input logic gmps);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= {3'd0, gmps, prob, ctx, sym};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predict_command(op, sym, ctx, prob, gmps);
    endtask

    // result checker and receiver stalls
    always @(posedge aclk) begin
        coded_item_t exp_it;
        if (aresetn && m_tvalid && m_tready) begin
            if (coded_q.size() == 0) begin
                $display("%0t: unexpected result kind=%0d data=%h last=%0d",
                         $realtime, m_tuser, m_tdata, m_tlast);
                n_errors++;
            end else begin
                exp_it = coded_q.pop_front();
                if (m_tuser !== exp_it.kind || m_tdata[7:0] !== exp_it.byte_val ||
                    m_tdata[39:8] !== exp_it.run || m_tlast !== exp_it.lst) begin
                    $display("%0t: mismatch expected kind=%0d byte=%h run=%0d last=%0d",
                             $realtime, exp_it.kind, exp_it.byte_val, exp_it.run,
                             exp_it.lst);
                    $display("%0t:          actual kind=%0d byte=%h run=%0d last=%0d",
                             $realtime, m_tuser, m_tdata[7:0], m_tdata[39:8], m_tlast);
                    n_errors++;
                end
            end
        end
    end

    initial begin
        int gap;
        forever begin
            @(posedge aclk);
            if (rx_hold) begin
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                gap = pick_gap();
                if (gap > 0) begin
                    @(posedge aclk);
                    m_tready <= 1'b0;
                    repeat (gap) @(posedge aclk);
                end
            end
        end
    end

    task automatic random_command(input int flush_pct);
        int r;
        logic [11:0] ctx;
        r = $urandom_range(0, 99);
        ctx = ($urandom_range(0, 3) == 0) ? 12'($urandom) : 12'($urandom_range(0, 7));
        if (r < flush_pct) begin
            send_command(OP_FLUSH, 1'($urandom), 12'($urandom), 15'($urandom), 1'($urandom));
            send_command(OP_RESTART, 1'($urandom), 12'($urandom), 15'($urandom),
                         1'($urandom));
        end else if (r < 70) begin
            send_command(OP_CTX, ($urandom_range(0, 3) != 0), ctx, 15'($urandom),
                         1'($urandom));
        end else begin
            send_command(OP_DIRECT, 1'($urandom), ctx, 15'($urandom), 1'($urandom));
        end
    endtask

    task automatic test_directed();
        send_command(OP_CTX, 1'b0, 12'd0, 15'd0, 1'b0);
        send_command(OP_CTX, 1'b1, 12'd4095, 15'd0, 1'b0);
        send_command(OP_CTX, 1'b1, 12'd4095, 15'd0, 1'b0);
        send_command(OP_DIRECT, 1'b1, 12'd0, 15'd0, 1'b0);
        send_command(OP_DIRECT, 1'b0, 12'd0, 15'h7fff, 1'b1);
        send_command(OP_DIRECT, 1'b1, 12'd0, 15'h7fff, 1'b0);
        send_command(OP_DIRECT, 1'b1, 12'd0, 15'd1, 1'b1);
        send_command(OP_DIRECT, 1'b0, 12'd0, 15'h5a1d, 1'b1);
        send_command(OP_FLUSH, 1'b0, 12'd0, 15'd0, 1'b0);
        send_command(OP_FLUSH, 1'b1, 12'hfff, 15'h7fff, 1'b1);
        send_command(OP_RESTART, 1'b0, 12'd0, 15'd0, 1'b0);
        // hold the code register near all ones to stack 0xff bytes
        repeat (8) send_command(OP_DIRECT, 1'b0, 12'd1, 15'h7ffe, 1'b1);
        send_command(OP_FLUSH, 1'b0, 12'd0, 15'd0, 1'b0);
        send_command(OP_RESTART, 1'b1, 12'hfff, 15'h7fff, 1'b1);
    endtask

    task automatic test_random();
        repeat (180) random_command(6);
    endtask

    task automatic test_backpressure();
        fork
            begin
                rx_hold = 1'b1;
                repeat (300) @(posedge aclk);
                rx_hold = 1'b0;
            end
            repeat (40) random_command(10);
        join
    endtask

    initial begin
        restart_coder();
        for (int i = 0; i < CONTEXTS_DEF; i++) begin
            ctx_st[i] = '0;
            ctx_mps[i] = 1'b0;
        end
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        test_directed();
        test_random();
        test_backpressure();
        send_command(OP_FLUSH, 1'b0, 12'd0, 15'd0, 1'b0);
        s_tvalid <= 1'b0;
        while (coded_q.size() != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
        if (n_errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
